### rtl/profile_tolerance_grouper_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the profile tolerance grouper
// Both forms sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PROFILE_TOLERANCE_GROUPER_DEFINES_SVH
`define PROFILE_TOLERANCE_GROUPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define PTG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ptg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptg_pkg
// Shared widths, reset values and register indexes of the profile grouper.
// ---------------------------------------------------------------------------
package ptg_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int TOL_W         = 15;
    localparam int CLI_W         = 6;
    localparam int GROUP_W       = 9;

    localparam int DEF_MAX_PROFILES = 256;
    localparam int DEF_MAX_SAMPLES  = 64;

    localparam logic [GROUP_W-1:0] GROUP_MAX   = 9'd511;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 15'd8192;
    localparam logic [CLI_W-1:0]   CLI_RESET   = 6'd63;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_CMP_LAST  = 1'b1;

endpackage

### rtl/ptg_cmp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptg_cmp
// Shared compare unit: flags a sample pair whose absolute difference
// reaches the tolerance.
// ---------------------------------------------------------------------------
module ptg_cmp
    import ptg_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] stored_sample,
    input  logic        [TOL_W-1:0]    tol,
    output logic                       mism
);

    logic signed [SAMPLE_W:0]   diff;
    logic        [SAMPLE_W-1:0] mag;

    always_comb
    begin
        diff = {sample[SAMPLE_W-1], sample} - {stored_sample[SAMPLE_W-1], stored_sample};
        // magnitude never exceeds 2^SAMPLE_W - 1, so it fits SAMPLE_W bits
        if (diff[SAMPLE_W])
        begin
            mag = SAMPLE_W'(-diff);
        end
        else
        begin
            mag = diff[SAMPLE_W-1:0];
        end
        mism = (mag >= SAMPLE_W'(tol));
    end

endmodule

### rtl/profile_tolerance_grouper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// profile_tolerance_grouper
// Groups incoming 1D profiles: a profile joins the current group when every
// compared sample lies within tolerance of one and the same stored profile.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    sample, last_sample
//  out       source     out_valid / out_stall  group, store_full
//  cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata
//
//  A compared sample, with profiles stored, stalls the input while one shared
//  compare unit walks the stored profiles, one per cycle, behind a one-port
//  read of the profile memory, then drains. A sample that is not compared
//  needs no scan; the last sample of a profile adds a finish state, held
//  while the previous item is still stalled at the output. The profile memory
//  needs no clearing after reset; the block accepts an item right after reset.
// ---------------------------------------------------------------------------
`include "profile_tolerance_grouper_defines.svh"

module profile_tolerance_grouper
    import ptg_pkg::*;
#(
    parameter int MAX_PROFILES = DEF_MAX_PROFILES,
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_sample,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic        [GROUP_W-1:0]  group,
    output logic                       store_full,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic        [APB_ADDR_W-1:0] paddr,
    input  logic        [APB_DATA_W-1:0] pwdata,
    output logic        [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH = MAX_PROFILES * MAX_SAMPLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_PROFILES);
    localparam int CW    = $clog2(MAX_PROFILES + 1);
    localparam int IW    = $clog2(MAX_SAMPLES + 1);
    localparam int XW    = (IW > CLI_W) ? IW : CLI_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TOL_W-1:0]   tol_reg;
    logic [CLI_W-1:0]   cli_reg;

    logic [PW-1:0]      p_reg;
    logic               cmp_valid_reg;
    logic [PW-1:0]      cmp_p_reg;
    logic [IW-1:0]      sample_index_reg;
    logic [CW-1:0]      stored_count_reg;
    logic [CW-1:0]      mis_cnt_reg;
    logic [GROUP_W-1:0] group_cnt_reg;
    logic               out_valid_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [IW-1:0]              cur_idx_reg;
    logic [GROUP_W-1:0]         out_group_reg;
    logic                       out_full_reg;

    logic [SAMPLE_W-1:0] store_mem [0:DEPTH-1];
    logic                flag_mem  [0:MAX_PROFILES-1];
    logic [SAMPLE_W-1:0] store_rd_reg;
    logic                flag_rd_reg;

    logic               accept;
    logic               cfg_wr;
    logic               compared;
    logic               have_room;
    logic               store_we;
    logic [AW-1:0]      store_waddr;
    logic [AW-1:0]      rd_addr;
    logic               scan_end;
    logic               mism;
    logic               flag_old;
    logic               flag_new;
    logic               out_free;
    logic               fin_go;
    logic               matched;
    logic [GROUP_W-1:0] group_upd;

    // ---------------- handshake and decode ----------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign group     = out_group_reg;
    assign store_full = out_full_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_TOLERANCE: prdata = APB_DATA_W'(tol_reg);
            REG_CMP_LAST:  prdata = APB_DATA_W'(cli_reg);
            default:       prdata = '0;
        endcase
    end

    assign compared  = (XW'(sample_index_reg) < XW'(MAX_SAMPLES))
                    && (XW'(sample_index_reg) <= XW'(cli_reg));
    assign have_room = (stored_count_reg < CW'(MAX_PROFILES));
    assign store_we  = accept && compared && have_room;
    assign store_waddr = AW'(stored_count_reg[PW-1:0]) * AW'(MAX_SAMPLES)
                       + AW'(sample_index_reg);
    assign rd_addr   = AW'(p_reg) * AW'(MAX_SAMPLES) + AW'(cur_idx_reg);
    assign scan_end  = (CW'(p_reg) == stored_count_reg - CW'(1));

    // ---------------- shared compare unit ----------------
    ptg_cmp u_cmp (
        .sample        (sample_reg),
        .stored_sample (store_rd_reg),
        .tol           (tol_reg),
        .mism          (mism)
    );

    // the first compared sample rewrites the flag of every stored profile, so no clearing is needed
    assign flag_old = (cur_idx_reg == '0) ? 1'b0 : flag_rd_reg;
    assign flag_new = flag_old || mism;

    // ---------------- finish ----------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign fin_go    = (state_reg == ST_FIN) && out_free;
    assign matched   = (stored_count_reg != '0) && (mis_cnt_reg != stored_count_reg);
    assign group_upd = (!matched && (group_cnt_reg < GROUP_MAX))
                     ? group_cnt_reg + GROUP_W'(1) : group_cnt_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (compared && (stored_count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (last_sample)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tol_reg          <= TOL_RESET;
            cli_reg          <= CLI_RESET;
            p_reg            <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_p_reg        <= '0;
            sample_index_reg <= '0;
            stored_count_reg <= '0;
            mis_cnt_reg      <= '0;
            group_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_TOLERANCE: tol_reg <= pwdata[TOL_W-1:0];
                    REG_CMP_LAST:  cli_reg <= pwdata[CLI_W-1:0];
                    default:       ;
                endcase
            end

            // advance the scan pointer; restart it for every new item
            if (state_reg == ST_SCAN)
            begin
                p_reg <= p_reg + PW'(1);
            end
            else
            begin
                p_reg <= '0;
            end
            cmp_valid_reg <= (state_reg == ST_SCAN);
            cmp_p_reg     <= p_reg;

            if (accept)
            begin
                if (sample_index_reg != IW'(MAX_SAMPLES))
                begin
                    sample_index_reg <= sample_index_reg + IW'(1);
                end
                if (sample_index_reg == '0)
                begin
                    mis_cnt_reg <= '0;
                end
            end
            else if (cmp_valid_reg && flag_new && !flag_old)
            begin
                mis_cnt_reg <= mis_cnt_reg + CW'(1);
            end

            if (fin_go)
            begin
                group_cnt_reg    <= group_upd;
                sample_index_reg <= '0;
                if (have_room)
                begin
                    stored_count_reg <= stored_count_reg + CW'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= sample;
            last_reg    <= last_sample;
            cur_idx_reg <= sample_index_reg;
        end
        if (fin_go)
        begin
            out_group_reg <= group_upd;
            out_full_reg  <= !have_room;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= sample;
        end
        store_rd_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmp_valid_reg)
        begin
            flag_mem[cmp_p_reg] <= flag_new;
        end
        flag_rd_reg <= flag_mem[p_reg];
    end

    // ---------------- assertions ----------------
    `PTG_ASSERT_NOW(a_mis_le_stored, 1'b1, mis_cnt_reg <= stored_count_reg, "mismatch count exceeds stored profiles")
    `PTG_ASSERT_NOW(a_stored_le_max, 1'b1, stored_count_reg <= CW'(MAX_PROFILES), "stored count exceeds store depth")
    `PTG_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN, CW'(p_reg) < stored_count_reg, "scan pointer past stored profiles")
    `PTG_ASSERT_NOW(a_out_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN, "result raised outside finish")
    `PTG_ASSERT_NEXT(a_group_nonzero, fin_go, out_group_reg != '0, "finished profile got group zero")

endmodule
